// File: src/alfr_pkg.sv
// Shared constants and types of the additive lagged Fibonacci generator.
package alfr_pkg;

	localparam int unsigned TableLength = 55;
	localparam int unsigned PtrW = $clog2(TableLength);
	localparam int unsigned WordW = 32;
	localparam int unsigned OutW = 31;

	localparam logic [PtrW-1:0] ShortStart = PtrW'(23);
	localparam logic [PtrW-1:0] LongStart = PtrW'(TableLength - 1);
	localparam logic [PtrW-1:0] LastIndex = PtrW'(TableLength - 1);

	localparam logic [WordW-1:0] LcgMul = 32'd69069;
	localparam logic [WordW-1:0] LcgAdd = 32'd1725307361;
	localparam logic [WordW-1:0] ResetSeed = 32'd1;

	localparam logic ActDraw = 1'b0;
	localparam logic ActSeed = 1'b1;

	typedef struct packed {
		logic en;
		logic [PtrW-1:0] addr;
		logic [WordW-1:0] data;
	} alfr_wr_t;

endpackage

// File: src/alfr_table.sv
// Lag table memory with one write port and two registered read ports.
module alfr_table (
	input logic clk,
	input alfr_pkg::alfr_wr_t wr,
	input logic [alfr_pkg::PtrW-1:0] addr_a,
	input logic [alfr_pkg::PtrW-1:0] addr_b,
	output logic [alfr_pkg::WordW-1:0] rd_a,
	output logic [alfr_pkg::WordW-1:0] rd_b
);

	logic [alfr_pkg::WordW-1:0] mem [alfr_pkg::TableLength];
	logic [alfr_pkg::WordW-1:0] rd_a_q;
	logic [alfr_pkg::WordW-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

// File: src/alfr_seeder.sv
// Fill sequencer that writes the table from the linear congruential sequence.
module alfr_seeder (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [alfr_pkg::WordW-1:0] seed,
	output alfr_pkg::alfr_wr_t wr,
	output logic busy
);

	logic busy_q;
	logic [alfr_pkg::WordW-1:0] x_q;
	logic [alfr_pkg::PtrW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			x_q <= alfr_pkg::ResetSeed;
			idx_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			x_q <= seed;
			idx_q <= '0;
		end else if (busy_q) begin
			x_q <= alfr_pkg::WordW'(x_q * alfr_pkg::LcgMul) + alfr_pkg::LcgAdd;
			idx_q <= idx_q + 1'b1;
			if (idx_q == alfr_pkg::LastIndex) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		wr.en = busy_q;
		wr.addr = idx_q;
		wr.data = x_q + (x_q >> 16);
	end

	assign busy = busy_q;

endmodule

// File: src/additive_lagged_fibonacci_rng_unit.sv
// Top level of the additive lagged Fibonacci generator with lags 24 and 55.
//
//   channel  direction  handshake           payload
//   input    in         in_valid/in_ready   action, seed_value
//   output   out        out_valid/out_ready random_value
//
// A draw reads both table entries in the accept cycle; in the draw state
// the unit adds them, writes the sum back and loads the output register.
// A seed item is accepted, its fill writes all 55 table entries, and the
// unit then returns to idle. After reset the same fill with seed one runs
// before the first item is accepted. A full output register holds a draw
// in its write cycle until the result is taken.
module additive_lagged_fibonacci_rng_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic action,
	input logic [31:0] seed_value,
	output logic out_valid,
	input logic out_ready,
	output logic [30:0] random_value
);

	typedef enum logic [2:0] {
		StIdle = 3'b001,
		StDraw = 3'b010,
		StFill = 3'b100
	} state_t;

	state_t state_q;
	logic [alfr_pkg::PtrW-1:0] short_q;
	logic [alfr_pkg::PtrW-1:0] long_q;
	logic out_valid_q;
	logic [alfr_pkg::OutW-1:0] random_value_q;

	logic accept;
	logic seed_start;
	logic draw_done;
	logic seed_busy;
	logic [alfr_pkg::WordW-1:0] rd_short;
	logic [alfr_pkg::WordW-1:0] rd_long;
	logic [alfr_pkg::WordW-1:0] sum;
	alfr_pkg::alfr_wr_t seed_wr;
	alfr_pkg::alfr_wr_t tbl_wr;

	assign in_ready = (state_q == StIdle);
	assign accept = in_valid && in_ready;
	assign seed_start = accept && (action == alfr_pkg::ActSeed);
	assign draw_done = (state_q == StDraw) && (!out_valid_q || out_ready);
	assign sum = rd_long + rd_short;

	always_comb begin
		if (draw_done) begin
			tbl_wr.en = 1'b1;
			tbl_wr.addr = long_q;
			tbl_wr.data = sum;
		end else begin
			tbl_wr = seed_wr;
		end
	end

	alfr_seeder u_seeder (
		.clk(clk),
		.arst_n(arst_n),
		.start(seed_start),
		.seed(seed_value),
		.wr(seed_wr),
		.busy(seed_busy)
	);

	alfr_table u_table (
		.clk(clk),
		.wr(tbl_wr),
		.addr_a(short_q),
		.addr_b(long_q),
		.rd_a(rd_short),
		.rd_b(rd_long)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StFill;
			short_q <= alfr_pkg::ShortStart;
			long_q <= alfr_pkg::LongStart;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						if (action == alfr_pkg::ActSeed) begin
							state_q <= StFill;
							short_q <= alfr_pkg::ShortStart;
							long_q <= alfr_pkg::LongStart;
						end else begin
							state_q <= StDraw;
						end
					end
				end
				StDraw: begin
					if (draw_done) begin
						state_q <= StIdle;
						short_q <= (short_q == '0) ? alfr_pkg::LastIndex : short_q - 1'b1;
						long_q <= (long_q == '0) ? alfr_pkg::LastIndex : long_q - 1'b1;
					end
				end
				StFill: begin
					if (!seed_busy) begin
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_done) begin
			random_value_q <= sum[alfr_pkg::OutW-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign random_value = random_value_q;

endmodule
